// ===== rtl/scancode_set1_key_decoder_defines.svh =====
// Assertion helpers used by the decoder back end (scd_back).
`ifndef SCANCODE_SET1_KEY_DECODER_DEFINES_SVH
`define SCANCODE_SET1_KEY_DECODER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scd: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define SCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scd: next-cycle check failed");

`endif

// ===== rtl/scd_pkg.sv =====
package scd_pkg;

    // item modes
    localparam logic [1:0] MODE_BYTE      = 2'd0;
    localparam logic [1:0] MODE_POP_CHAR  = 2'd1;
    localparam logic [1:0] MODE_POP_EVENT = 2'd2;

    // scancodes (release bit stripped where 7 bits)
    localparam logic [7:0] SC_PREFIX = 8'hE0;
    localparam logic [6:0] SC_SHIFT_L = 7'h2A;
    localparam logic [6:0] SC_SHIFT_R = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_CTRL   = 7'h1D;
    localparam logic [6:0] SC_UP     = 7'h48;
    localparam logic [6:0] SC_DOWN   = 7'h50;
    localparam logic [6:0] SC_LEFT   = 7'h4B;
    localparam logic [6:0] SC_RIGHT  = 7'h4D;
    localparam logic [6:0] SC_HOME   = 7'h47;
    localparam logic [6:0] SC_END    = 7'h4F;
    localparam logic [6:0] SC_PGUP   = 7'h49;
    localparam logic [6:0] SC_PGDN   = 7'h51;
    localparam logic [6:0] SC_BR_C   = 7'h27;
    localparam logic [6:0] SC_BR_SEMI  = 7'h35;
    localparam logic [6:0] SC_BR_TILDE = 7'h28;

    localparam logic LAYOUT_US = 1'b0;
    localparam logic LAYOUT_BR = 1'b1;

    localparam logic [6:0] ASCII_A_LOW = 7'h61;
    localparam logic [6:0] ASCII_Z_LOW = 7'h7A;
    localparam logic [6:0] CTRL_BASE   = 7'h60;

    localparam int MAP_LEN   = 60;
    localparam int OPQ_DEPTH = 2;

    localparam logic [6:0] US_PLAIN [MAP_LEN] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00
    };

    localparam logic [6:0] US_UPPER [MAP_LEN] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00
    };

    typedef struct packed {
        logic       pop_ch;
        logic       pop_ev;
        logic       ev_push;
        logic [8:0] ev_data;   // {pressed, extended, code}
        logic       ch_push;
        logic [7:0] ch_data;   // {nav flag, char or nav index}
    } t_op;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } t_nav;

    function automatic logic [6:0] lookup_char(input logic [6:0] code, input logic upper,
                                               input logic layout);
        logic [6:0] res;
        res = 7'h00;
        if (code < 7'(MAP_LEN)) begin
            res = upper ? US_UPPER[code[5:0]] : US_PLAIN[code[5:0]];
            if (layout == LAYOUT_BR) begin
                if (code == SC_BR_C)          res = upper ? 7'h43 : 7'h63;
                else if (code == SC_BR_SEMI)  res = upper ? 7'h3A : 7'h3B;
                else if (code == SC_BR_TILDE) res = upper ? 7'h5E : 7'h7E;
            end
        end
        return res;
    endfunction

    function automatic t_nav nav_lookup(input logic [6:0] code);
        t_nav res;
        res = '{hit: 1'b1, idx: 3'd0};
        case (code)
            SC_UP:    res.idx = 3'd0;
            SC_DOWN:  res.idx = 3'd1;
            SC_LEFT:  res.idx = 3'd2;
            SC_RIGHT: res.idx = 3'd3;
            SC_HOME:  res.idx = 3'd4;
            SC_END:   res.idx = 3'd5;
            SC_PGUP:  res.idx = 3'd6;
            SC_PGDN:  res.idx = 3'd7;
            default:  res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/scd_ifs.sv =====
interface scd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] scan_byte;

    modport source (output valid, output mode, output scan_byte, input ready);
    modport sink   (input valid, input mode, input scan_byte, output ready);
endinterface

interface scd_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface scd_out_if;
    logic       valid;
    logic       ready;
    logic       present;
    logic [6:0] char_code;
    logic       is_nav;
    logic [2:0] nav_key;
    logic       pressed;
    logic       extended;
    logic [6:0] scan_code;

    modport source (output valid, output present, output char_code, output is_nav,
                    output nav_key, output pressed, output extended, output scan_code,
                    input ready);
    modport sink   (input valid, input present, input char_code, input is_nav,
                    input nav_key, input pressed, input extended, input scan_code,
                    output ready);
endinterface

// ===== rtl/scd_front.sv =====
module scd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scd_in_if.sink       i_in,
    scd_cfg_if.sink      i_cfg,
    input  logic         i_q_full,
    output logic         o_q_push,
    output scd_pkg::t_op o_q_op
);
    import scd_pkg::*;

    logic r_layout, n_layout;
    logic r_shift, n_shift;
    logic r_caps, n_caps;
    logic r_ctrl, n_ctrl;
    logic r_prefix, n_prefix;

    logic       acc;
    logic [6:0] code;
    logic       rel;
    logic [6:0] plain;
    logic [6:0] ch;
    logic       letter;
    logic       upper;
    t_nav       nav;
    t_op        op_c;

    assign i_in.ready  = !i_q_full;
    assign i_cfg.ready = 1'b1;
    assign acc         = i_in.valid && i_in.ready;

    assign code   = i_in.scan_byte[6:0];
    assign rel    = i_in.scan_byte[7];
    assign plain  = lookup_char(code, 1'b0, r_layout);
    assign letter = (plain >= ASCII_A_LOW) && (plain <= ASCII_Z_LOW);
    assign upper  = letter ? (r_shift ^ r_caps) : r_shift;
    assign ch     = lookup_char(code, upper, r_layout);
    assign nav    = nav_lookup(code);

    always_comb begin
        n_layout = i_cfg.valid ? i_cfg.data : r_layout;
        n_shift  = r_shift;
        n_caps   = r_caps;
        n_ctrl   = r_ctrl;
        n_prefix = r_prefix;
        op_c     = '0;
        if (acc) begin
            unique case (i_in.mode)
                MODE_BYTE: begin
                    if (i_in.scan_byte == SC_PREFIX) begin
                        n_prefix = 1'b1;
                    end else begin
                        op_c.ev_push = 1'b1;
                        op_c.ev_data = {~rel, r_prefix, code};
                        if (r_prefix) begin
                            n_prefix = 1'b0;
                            if (code == SC_CTRL) begin
                                n_ctrl = ~rel;
                            end else if (!rel && nav.hit) begin
                                op_c.ch_push = 1'b1;
                                op_c.ch_data = {1'b1, 4'b0000, nav.idx};
                            end
                        end else if (rel) begin
                            if (code == SC_SHIFT_L || code == SC_SHIFT_R) n_shift = 1'b0;
                            else if (code == SC_CTRL)                     n_ctrl  = 1'b0;
                        end else if (code == SC_SHIFT_L || code == SC_SHIFT_R) begin
                            n_shift = 1'b1;
                        end else if (code == SC_CTRL) begin
                            n_ctrl = 1'b1;
                        end else if (code == SC_CAPS) begin
                            n_caps = ~r_caps;
                        end else if (ch != 7'h00 && (!r_ctrl || letter)) begin
                            // with Ctrl held a letter becomes its control code
                            op_c.ch_push = 1'b1;
                            op_c.ch_data = {1'b0, r_ctrl ? 7'(plain - CTRL_BASE) : ch};
                        end
                    end
                end
                MODE_POP_CHAR:  op_c.pop_ch = 1'b1;
                MODE_POP_EVENT: op_c.pop_ev = 1'b1;
                default: ;
            endcase
        end
    end

    assign o_q_op   = op_c;
    assign o_q_push = op_c.pop_ch | op_c.pop_ev | op_c.ev_push | op_c.ch_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout <= LAYOUT_US;
            r_shift  <= 1'b0;
            r_caps   <= 1'b0;
            r_ctrl   <= 1'b0;
            r_prefix <= 1'b0;
        end else begin
            r_layout <= n_layout;
            r_shift  <= n_shift;
            r_caps   <= n_caps;
            r_ctrl   <= n_ctrl;
            r_prefix <= n_prefix;
        end
    end

endmodule

// ===== rtl/scd_opq.sv =====
module scd_opq (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  scd_pkg::t_op i_op,
    output logic         o_full,
    output logic         o_valid,
    output scd_pkg::t_op o_op,
    input  logic         i_pop
);
    import scd_pkg::*;

    localparam int AW = $clog2(OPQ_DEPTH);
    localparam int CNTW = $clog2(OPQ_DEPTH + 1);

    t_op             r_ent [OPQ_DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_cnt == CNTW'(OPQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_ent[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop)      n_cnt = r_cnt + 1'b1;
        else if (do_pop && !do_push) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/scd_back.sv =====
`include "scancode_set1_key_decoder_defines.svh"

module scd_back #(
    parameter int CHAR_QUEUE_DEPTH  = 128,
    parameter int EVENT_QUEUE_DEPTH = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_valid,
    input  scd_pkg::t_op i_op,
    output logic         o_op_take,
    scd_out_if.source    o_out
);
    import scd_pkg::*;

    localparam int CW = $clog2(CHAR_QUEUE_DEPTH);
    localparam int EW = $clog2(EVENT_QUEUE_DEPTH);

    logic [7:0]    r_cmem [CHAR_QUEUE_DEPTH];
    logic [8:0]    r_emem [EVENT_QUEUE_DEPTH];
    logic [7:0]    r_crd;
    logic [8:0]    r_erd;

    logic [CW-1:0] r_cwp, n_cwp, r_crp, n_crp;
    logic [EW-1:0] r_ewp, n_ewp, r_erp, n_erp;
    logic [CW-1:0] c_nxt_w, c_nxt_r;
    logic [EW-1:0] e_nxt_w, e_nxt_r;
    logic          c_full, c_empty, e_full, e_empty;

    logic r_pend, n_pend;         // read issued, data lands next cycle
    logic r_pend_ch, n_pend_ch;   // pending pop is from the char queue
    logic r_pend_hit, n_pend_hit; // popped queue was not empty
    logic r_out_vld, n_out_vld;

    logic       r_present;
    logic [6:0] r_char_code;
    logic       r_is_nav;
    logic [2:0] r_nav_key;
    logic       r_pressed;
    logic       r_extended;
    logic [6:0] r_scan_code;

    logic is_pop;
    logic take;
    logic c_wr, e_wr;

    assign c_nxt_w = (r_cwp == CW'(CHAR_QUEUE_DEPTH - 1)) ? '0 : r_cwp + 1'b1;
    assign c_nxt_r = (r_crp == CW'(CHAR_QUEUE_DEPTH - 1)) ? '0 : r_crp + 1'b1;
    assign e_nxt_w = (r_ewp == EW'(EVENT_QUEUE_DEPTH - 1)) ? '0 : r_ewp + 1'b1;
    assign e_nxt_r = (r_erp == EW'(EVENT_QUEUE_DEPTH - 1)) ? '0 : r_erp + 1'b1;
    assign c_full  = c_nxt_w == r_crp;
    assign e_full  = e_nxt_w == r_erp;
    assign c_empty = r_crp == r_cwp;
    assign e_empty = r_erp == r_ewp;

    // pops wait for the output side to drain; pushes go straight through
    assign is_pop    = i_op.pop_ch | i_op.pop_ev;
    assign take      = i_op_valid && (!is_pop || (!r_pend && !r_out_vld));
    assign o_op_take = take;
    assign c_wr      = take && i_op.ch_push && !c_full;
    assign e_wr      = take && i_op.ev_push && !e_full;

    always_comb begin
        n_cwp      = c_wr ? c_nxt_w : r_cwp;
        n_ewp      = e_wr ? e_nxt_w : r_ewp;
        n_crp      = r_crp;
        n_erp      = r_erp;
        n_pend     = take && is_pop;
        n_pend_ch  = i_op.pop_ch;
        n_pend_hit = i_op.pop_ch ? !c_empty : !e_empty;
        if (take && i_op.pop_ch && !c_empty) n_crp = c_nxt_r;
        if (take && i_op.pop_ev && !e_empty) n_erp = e_nxt_r;
        n_out_vld = r_out_vld;
        if (r_pend)           n_out_vld = 1'b1;
        else if (o_out.ready) n_out_vld = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (c_wr) begin
            r_cmem[r_cwp] <= i_op.ch_data;
        end
        if (take && i_op.pop_ch) begin
            r_crd <= r_cmem[r_crp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_wr) begin
            r_emem[r_ewp] <= i_op.ev_data;
        end
        if (take && i_op.pop_ev) begin
            r_erd <= r_emem[r_erp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_present   <= r_pend_hit;
            r_char_code <= '0;
            r_is_nav    <= 1'b0;
            r_nav_key   <= '0;
            r_pressed   <= 1'b0;
            r_extended  <= 1'b0;
            r_scan_code <= '0;
            if (r_pend_hit && r_pend_ch) begin
                r_is_nav <= r_crd[7];
                if (r_crd[7]) r_nav_key   <= r_crd[2:0];
                else          r_char_code <= r_crd[6:0];
            end else if (r_pend_hit) begin
                r_pressed   <= r_erd[8];
                r_extended  <= r_erd[7];
                r_scan_code <= r_erd[6:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwp      <= '0;
            r_crp      <= '0;
            r_ewp      <= '0;
            r_erp      <= '0;
            r_pend     <= 1'b0;
            r_pend_ch  <= 1'b0;
            r_pend_hit <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_cwp      <= n_cwp;
            r_crp      <= n_crp;
            r_ewp      <= n_ewp;
            r_erp      <= n_erp;
            r_pend     <= n_pend;
            r_pend_ch  <= n_pend_ch;
            r_pend_hit <= n_pend_hit;
            r_out_vld  <= n_out_vld;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.present   = r_present;
    assign o_out.char_code = r_char_code;
    assign o_out.is_nav    = r_is_nav;
    assign o_out.nav_key   = r_nav_key;
    assign o_out.pressed   = r_pressed;
    assign o_out.extended  = r_extended;
    assign o_out.scan_code = r_scan_code;

    `SCD_ASSERT_NEXT(a_pend_to_out, i_clk, i_rst_n, r_pend, r_out_vld)
    `SCD_ASSERT_NEXT(a_cwp_step, i_clk, i_rst_n, 1'b1, $stable(r_cwp) || (r_cwp == $past(c_nxt_w)))
    `SCD_ASSERT_NEXT(a_ewp_step, i_clk, i_rst_n, 1'b1, $stable(r_ewp) || (r_ewp == $past(e_nxt_w)))

endmodule

// ===== rtl/scancode_set1_key_decoder.sv =====
// Scancode set 1 keyboard decoder. Each input item carries a scancode byte or
// pops the character queue or the event queue; only pops give a result. The
// front end decodes bytes (E0 prefix, Shift, Ctrl, Caps Lock, US or Brazilian
// keymap) and accepts one item per cycle while its two-entry command queue has
// room. The back end retires one queued push per cycle; a pop reads its queue
// memory (registered read), then loads the output register, which shows the
// result. A further pop waits until that output register has been taken, so
// the back end takes no new pop while an earlier one is still in flight. The
// queues start empty after reset; no clearing pass is run.
module scancode_set1_key_decoder #(
    parameter int CHAR_QUEUE_DEPTH  = 128,
    parameter int EVENT_QUEUE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    scd_in_if.sink    i_in,
    scd_cfg_if.sink   i_cfg,
    scd_out_if.source o_out
);
    import scd_pkg::*;

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_take;
    t_op  q_in_op;
    t_op  q_out_op;

    scd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_op   (q_in_op)
    );

    scd_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_out_op),
        .i_pop   (q_take)
    );

    scd_back #(
        .CHAR_QUEUE_DEPTH  (CHAR_QUEUE_DEPTH),
        .EVENT_QUEUE_DEPTH (EVENT_QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_out_op),
        .o_op_take  (q_take),
        .o_out      (o_out)
    );

endmodule

// ===== test/scancode_set1_key_decoder_test.sv =====
`timescale 1ns / 100ps

module scancode_set1_key_decoder_test;
    import scd_pkg::*;

    localparam int CHAR_Q_DEPTH   = 128;
    localparam int EVENT_Q_DEPTH  = 64;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int LONG_HOLD      = 500;
    localparam int PHASE_ITEMS    = 480;

    localparam logic [6:0] NAV_CODES [8] = '{
        SC_UP, SC_DOWN, SC_LEFT, SC_RIGHT, SC_HOME, SC_END, SC_PGUP, SC_PGDN
    };
    localparam logic [6:0] LETTER_CODES [26] = '{
        7'h10, 7'h11, 7'h12, 7'h13, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19,
        7'h1E, 7'h1F, 7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
        7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h30, 7'h31, 7'h32
    };

    typedef struct {
        logic [1:0] mode;
        logic [7:0] scan_byte;
        int         gap;
    } key_item_t;

    typedef struct packed {
        logic       present;
        logic [6:0] char_code;
        logic       is_nav;
        logic [2:0] nav_key;
        logic       pressed;
        logic       extended;
        logic [6:0] scan_code;
    } pop_result_t;

    logic i_clk;
    logic i_rst_n;

    scd_in_if  key_if ();
    scd_cfg_if cfg_if ();
    scd_out_if pop_if ();

    scancode_set1_key_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (key_if),
        .i_cfg   (cfg_if),
        .o_out   (pop_if)
    );

    // decoder state as predicted
    logic       layout_br;
    logic       shift_on, caps_on, ctrl_on, e0_armed;
    logic [7:0] char_fifo [$];
    logic [8:0] event_fifo [$];

    key_item_t   key_items [$];
    pop_result_t pop_results_due [$];

    int unsigned fail_count, cycle_count, n_queued, quiet_left;
    int unsigned n_bytes, n_char_pops, n_event_pops, n_unused, n_drops, n_empty;
    int unsigned n_nav, n_results;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     pop_results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic [6:0] map_key(input logic [6:0] code, input logic upper);
        logic [6:0] c;
        c = 7'h00;
        if (code < 7'(MAP_LEN)) begin
            c = upper ? US_UPPER[code[5:0]] : US_PLAIN[code[5:0]];
            if (layout_br) begin
                if (code == SC_BR_C)          c = upper ? 7'h43 : 7'h63;   // C c
                else if (code == SC_BR_SEMI)  c = upper ? 7'h3A : 7'h3B;   // : ;
                else if (code == SC_BR_TILDE) c = upper ? 7'h5E : 7'h7E;   // ^ ~
            end
        end
        return c;
    endfunction

    function automatic int nav_slot(input logic [6:0] code);
        for (int i = 0; i < 8; i++)
            if (NAV_CODES[i] == code) return i;
        return -1;
    endfunction

    task automatic push_char(input logic [7:0] v);
        if (char_fifo.size() < CHAR_Q_DEPTH - 1) char_fifo.push_back(v);
        else n_drops++;
    endtask

    task automatic push_event(input logic [8:0] v);
        if (event_fifo.size() < EVENT_Q_DEPTH - 1) event_fifo.push_back(v);
        else n_drops++;
    endtask

    task automatic decode_scan_byte(input logic [7:0] sc);
        logic [6:0] code, plain, c;
        logic       rel, ext, letter, upper;
        int         nav;
        code = sc[6:0];
        rel  = sc[7];
        if (sc == SC_PREFIX) begin
            e0_armed = 1'b1;
            return;
        end
        ext = e0_armed;
        push_event({~rel, ext, code});
        if (ext) begin
            e0_armed = 1'b0;
            if (code == SC_CTRL) begin
                ctrl_on = ~rel;
                return;
            end
            if (rel) return;
            nav = nav_slot(code);
            if (nav >= 0) begin
                push_char({1'b1, 4'd0, 3'(nav)});
                n_nav++;
            end
            return;
        end
        if (rel) begin
            if (code == SC_SHIFT_L || code == SC_SHIFT_R) shift_on = 1'b0;
            else if (code == SC_CTRL) ctrl_on = 1'b0;
            return;
        end
        if (code == SC_SHIFT_L || code == SC_SHIFT_R) begin
            shift_on = 1'b1;
            return;
        end
        if (code == SC_CTRL) begin
            ctrl_on = 1'b1;
            return;
        end
        if (code == SC_CAPS) begin
            caps_on = ~caps_on;
            return;
        end
        plain  = map_key(code, 1'b0);
        letter = (plain >= ASCII_A_LOW) && (plain <= ASCII_Z_LOW);
        upper  = letter ? (shift_on ^ caps_on) : shift_on;
        c      = map_key(code, upper);
        if (c == 7'h00) return;
        if (ctrl_on) begin
            if (!letter) return;
            c = plain - CTRL_BASE;
        end
        push_char({1'b0, c});
    endtask

    task automatic predict_item(input logic [1:0] m, input logic [7:0] b);
        pop_result_t r;
        logic [7:0]  cv;
        logic [8:0]  ev;
        r = '0;
        case (m)
            MODE_BYTE: begin
                n_bytes++;
                decode_scan_byte(b);
            end
            MODE_POP_CHAR: begin
                n_char_pops++;
                if (char_fifo.size() != 0) begin
                    cv = char_fifo.pop_front();
                    r.present = 1'b1;
                    if (cv[7]) begin
                        r.is_nav  = 1'b1;
                        r.nav_key = cv[2:0];
                    end else begin
                        r.char_code = cv[6:0];
                    end
                end else begin
                    n_empty++;
                end
                pop_results_due.push_back(r);
            end
            MODE_POP_EVENT: begin
                n_event_pops++;
                if (event_fifo.size() != 0) begin
                    ev = event_fifo.pop_front();
                    r.present   = 1'b1;
                    r.pressed   = ev[8];
                    r.extended  = ev[7];
                    r.scan_code = ev[6:0];
                end else begin
                    n_empty++;
                end
                pop_results_due.push_back(r);
            end
            default: n_unused++;
        endcase
    endtask

    // ---------------- driver ----------------

    int unsigned wait_left;

    always @(posedge i_clk) begin : key_driver
        key_item_t it;
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
            wait_left = 0;
        end else begin
            if (key_if.valid && key_if.ready) predict_item(key_if.mode, key_if.scan_byte);
            if (!key_if.valid || key_if.ready) begin
                if (wait_left > 0) begin
                    wait_left--;
                    key_if.valid <= 1'b0;
                end else if (key_items.size() != 0 && key_items[0].gap != 0) begin
                    wait_left = key_items[0].gap - 1;
                    key_items[0].gap = 0;
                    key_if.valid <= 1'b0;
                end else if (key_items.size() != 0) begin
                    it = key_items.pop_front();
                    key_if.valid     <= 1'b1;
                    key_if.mode      <= it.mode;
                    key_if.scan_byte <= it.scan_byte;
                end else begin
                    key_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    int unsigned hold_left, calm_left, taken_seen;

    always @(posedge i_clk) begin : pop_ready_gen
        int r;
        if (!i_rst_n) begin
            pop_if.ready <= 1'b0;
            hold_left  = 0;
            calm_left  = 0;
            taken_seen = 0;
        end else begin
            if (pop_if.valid && pop_if.ready) begin
                taken_seen++;
                // long back-pressure so the input side fills and stalls
                if (taken_seen == 200 || taken_seen == 900) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop_if.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                pop_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) calm_left = $urandom_range(50, 200);
                else if (r < 6) hold_left = $urandom_range(8, 40);
                else if (r < 30) hold_left = $urandom_range(0, 2);
                pop_if.ready <= (r < 3) || (r >= 30);
            end
        end
    end

    always @(posedge i_clk) begin : pop_checker
        pop_result_t got, want;
        if (i_rst_n && pop_if.valid && pop_if.ready) begin
            n_results++;
            got = '{pop_if.present, pop_if.char_code, pop_if.is_nav, pop_if.nav_key,
                    pop_if.pressed, pop_if.extended, pop_if.scan_code};
            if (pop_results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pop result %h at cycle %0d", got, cycle_count);
            end else begin
                want = pop_results_due.pop_front();
                if (got.present !== want.present || got.char_code !== want.char_code ||
                    got.is_nav !== want.is_nav || got.nav_key !== want.nav_key ||
                    got.pressed !== want.pressed || got.extended !== want.extended ||
                    got.scan_code !== want.scan_code) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch at result %0d: got  p=%b ch=%h nav=%b/%0d ev=%b/%b/%h",
                                 n_results, got.present, got.char_code, got.is_nav,
                                 got.nav_key, got.pressed, got.extended, got.scan_code);
                        $display("                     want p=%b ch=%h nav=%b/%0d ev=%b/%b/%h",
                                 want.present, want.char_code, want.is_nav, want.nav_key,
                                 want.pressed, want.extended, want.scan_code);
                    end
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic queue_item(input logic [1:0] m, input logic [7:0] b);
        key_item_t it;
        it.mode      = m;
        it.scan_byte = b;
        if (quiet_left > 0) begin
            quiet_left--;
            it.gap = 0;
        end else begin
            it.gap = pick_gap();
            if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(40, 120);
        end
        key_items.push_back(it);
        if (m != MODE_UNUSED) n_queued++;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        queue_item(MODE_BYTE, b);
    endtask

    task automatic queue_pop(input logic [1:0] m);
        queue_item(m, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_random_group();
        int         kind, sel;
        logic [6:0] k, sh;
        logic       with_shift, with_ctrl;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // well-formed key tap, possibly under modifiers
            k = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 63))
                                            : 7'($urandom_range(64, 127));
            sh = $urandom_range(0, 1) ? SC_SHIFT_L : SC_SHIFT_R;
            with_shift = ($urandom_range(0, 9) < 3);
            with_ctrl  = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) queue_byte({1'b0, SC_CAPS});
            if (with_shift) queue_byte({1'b0, sh});
            if (with_ctrl) queue_byte({1'b0, SC_CTRL});
            queue_byte({1'b0, k});
            queue_byte({1'b1, k});
            if (with_ctrl) queue_byte({1'b1, SC_CTRL});
            if (with_shift) queue_byte({1'b1, sh});
        end else if (kind < 50) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) k = NAV_CODES[$urandom_range(0, 7)];
            else if (sel < 17) k = SC_CTRL;
            else k = 7'($urandom_range(0, 127));
            queue_byte(SC_PREFIX);
            queue_byte({1'b0, k});
            if ($urandom_range(0, 3) != 0) begin
                queue_byte(SC_PREFIX);
                queue_byte({1'b1, k});
            end
        end else if (kind < 82) begin
            repeat ($urandom_range(1, 4))
                queue_pop($urandom_range(0, 2) != 0 ? MODE_POP_CHAR : MODE_POP_EVENT);
        end else if (kind < 92) begin
            queue_byte(8'($urandom_range(0, 255)));
        end else if (kind < 96) begin
            queue_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
        end else begin
            // broken sequences: dangling prefix or a release with no press
            if ($urandom_range(0, 1)) queue_byte(SC_PREFIX);
            else queue_byte({1'b1, 7'($urandom_range(0, 127))});
        end
    endtask

    // overrun both queues with key repeats, then drain them past empty
    task automatic fill_and_drain();
        repeat (150) queue_byte({1'b0, LETTER_CODES[$urandom_range(0, 25)]});
        for (int i = 0; i < 140; i++) begin
            queue_pop(MODE_POP_CHAR);
            if (i % 2 == 0) queue_pop(MODE_POP_EVENT);
        end
    endtask

    task automatic queue_directed();
        queue_pop(MODE_POP_CHAR);
        queue_pop(MODE_POP_EVENT);
        queue_item(MODE_UNUSED, 8'hFF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(SC_PREFIX);
        queue_byte(SC_PREFIX);          // prefix stays armed
        queue_byte({1'b0, SC_UP});
        queue_byte(SC_PREFIX);
        queue_byte({1'b1, SC_UP});
        queue_byte(SC_PREFIX);
        queue_byte({1'b0, SC_CTRL});    // right ctrl down
        queue_byte(8'h1E);              // letter under ctrl
        queue_byte(8'h02);              // digit under ctrl, dropped
        queue_byte(SC_PREFIX);
        queue_byte({1'b1, SC_CTRL});
        queue_byte({1'b0, SC_SHIFT_L});
        queue_byte(8'h1E);
        queue_byte({1'b1, SC_SHIFT_L});
        queue_byte({1'b0, SC_CAPS});
        queue_byte(8'h10);
        queue_byte({1'b0, SC_CAPS});
        queue_byte(SC_PREFIX);
        queue_byte(8'h52);              // extended key with no nav meaning
        queue_byte(8'h3B);              // no map entry
    endtask

    task automatic wait_quiet();
        while (key_items.size() != 0 || key_if.valid || pop_results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_layout(input logic v);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        layout_br = v;
        @(negedge i_clk);
    endtask

    initial begin : main_seq
        int unsigned phase_start;
        i_rst_n          = 1'b0;
        key_if.valid     = 1'b0;
        key_if.mode      = MODE_BYTE;
        key_if.scan_byte = 8'h00;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = LAYOUT_US;
        pop_if.ready     = 1'b0;
        layout_br = LAYOUT_US;
        shift_on  = 1'b0;
        caps_on   = 1'b0;
        ctrl_on   = 1'b0;
        e0_armed  = 1'b0;
        fail_count = 0; cycle_count = 0; n_queued = 0; quiet_left = 0;
        n_bytes = 0; n_char_pops = 0; n_event_pops = 0; n_unused = 0;
        n_drops = 0; n_empty = 0; n_nav = 0; n_results = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) write_layout(LAYOUT_BR);
            if (phase == 2) write_layout(LAYOUT_US);
            if (phase == 3) write_layout(LAYOUT_BR);
            phase_start = n_queued;
            if (phase == 0) queue_directed();
            while (n_queued - phase_start < 130) add_random_group();
            fill_and_drain();
            while (n_queued - phase_start < PHASE_ITEMS) add_random_group();
            wait_quiet();
        end

        if (pop_results_due.size() != 0) fail_count++;
        $display("Run: %0d scancode bytes, %0d char pops, %0d event pops, %0d mode-3 items.",
                 n_bytes, n_char_pops, n_event_pops, n_unused);
        $display("Both layouts, %0d nav entries, %0d full-queue drops, %0d empty pops.",
                 n_nav, n_drops, n_empty);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failures", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
